/* rtl/core/rfc_pkg.sv */
// ----------------------------------------------------------------------------
// rfc_pkg
// Types, constants and CRC helpers shared by the reply frame checker.
// ----------------------------------------------------------------------------
package rfc_pkg;

    localparam int HDR_BYTES = 10;
    localparam int CRC_BYTES = 4;
    localparam int ADDR_W    = 5;

    localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;
    localparam logic [31:0] CRC_SEED = 32'hFFFF_FFFF;

    // register indexes, taken from paddr[4:2]
    localparam logic [2:0] REG_ACK   = 3'd0;
    localparam logic [2:0] REG_NACK  = 3'd1;
    localparam logic [2:0] REG_BUSY  = 3'd2;
    localparam logic [2:0] REG_READ  = 3'd3;
    localparam logic [2:0] REG_WRITE = 3'd4;

    typedef enum logic [2:0] {
        STAT_OK         = 3'd0,
        STAT_SHORT_HDR  = 3'd1,
        STAT_SHORT_BODY = 3'd2,
        STAT_LONG       = 3'd3,
        STAT_CRC_BAD    = 3'd4
    } frame_status_t;

    typedef enum logic [1:0] {
        VERD_ACK      = 2'd0,
        VERD_ACCEPTED = 2'd1,
        VERD_NACK     = 2'd2,
        VERD_BUSY     = 2'd3
    } verdict_t;

    typedef struct packed {
        logic [7:0]  rx_byte;
        logic        last_byte;
        logic [31:0] expected_seq;
    } in_word_t;

    typedef struct packed {
        logic [2:0]  frame_status;
        logic [1:0]  verdict;
        logic        seq_matches;
        logic [31:0] reason_seen;
        logic [31:0] seq_seen;
        logic [7:0]  payload_length;
        logic [8:0]  bytes_received;
        logic [31:0] computed_crc;
    } out_word_t;

    // frame state captured at the last byte
    typedef struct packed {
        logic [8:0]  byte_count;
        logic [7:0]  length;
        logic [31:0] seq;
        logic [31:0] reason;
        logic [31:0] crc;
        logic [31:0] rx_crc;
        logic [31:0] expected_seq;
    } snap_t;

    typedef struct packed {
        logic [31:0] ack_reason;
        logic [31:0] nack_reason;
        logic [31:0] busy_reason;
        logic [31:0] read_reason;
        logic [31:0] write_reason;
    } reasons_t;

    // four msb-first shifts of the crc register
    function automatic logic [31:0] crc_nibble(input logic [31:0] crc);
        logic [31:0] c;
        c = crc;
        for (int k = 0; k < 4; k++) begin
            c = c[31] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    // one 32-bit word folded in, a nibble per step
    function automatic logic [31:0] crc_word(input logic [31:0] crc, input logic [31:0] word);
        logic [31:0] c;
        c = crc ^ word;
        for (int n = 0; n < 8; n++) begin
            c = crc_nibble(c);
        end
        return c;
    endfunction

endpackage

/* rtl/core/reply_frame_checker.sv */
// ----------------------------------------------------------------------------
// reply_frame_checker
// Byte-serial reply frame checker: CRC-32 over header and payload, length,
// sequence and reason classification, one result word per frame.
// ----------------------------------------------------------------------------
// Takes one byte per clock while rx_stall is low, with no gaps required; the
// word carrying last_byte gives a result word via snap_reg and res_word_reg. The
// per-byte cost is set by the CRC word update, a nibble-unrolled fold of
// each completed 32-bit little-endian word done in the accepting cycle. The
// end-of-frame snapshot register and the result register let a new frame
// stream in while the previous result waits; rx_stall rises only when a
// second result is pending behind a stalled one. Reason codes are set over
// the APB port at byte addresses 0, 4, 8, 12, 16 and should be written while
// no frame is in flight.
module reply_frame_checker
#(
    parameter int MAX_PAYLOAD = 255
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       rx_valid,
    output logic                       rx_stall,
    input  rfc_pkg::in_word_t          rx_word,
    output logic                       res_valid,
    input  logic                       res_stall,
    output rfc_pkg::out_word_t         res_word,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [rfc_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    rfc_pkg::reasons_t reasons;
    rfc_pkg::snap_t    snap;
    logic              snap_valid;
    logic              snap_take;

    rfc_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .reasons (reasons)
    );

    rfc_frame
    #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    )
    u_frame
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx_valid   (rx_valid),
        .rx_stall   (rx_stall),
        .rx_word    (rx_word),
        .snap_take  (snap_take),
        .snap_valid (snap_valid),
        .snap       (snap)
    );

    rfc_judge u_judge
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .snap_valid (snap_valid),
        .snap       (snap),
        .snap_take  (snap_take),
        .reasons    (reasons),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res_word   (res_word)
    );

endmodule

/* rtl/core/rfc_regs.sv */
// ----------------------------------------------------------------------------
// rfc_regs
// APB register file holding the five reason codes.
// ----------------------------------------------------------------------------
module rfc_regs
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [rfc_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output rfc_pkg::reasons_t          reasons
);

    rfc_pkg::reasons_t reasons_reg;
    logic [2:0]        index;
    logic              write_en;

    assign index    = paddr[4:2];
    assign write_en = psel && penable && pwrite;
    assign pready   = 1'b1;
    assign reasons  = reasons_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reasons_reg.ack_reason   <= 32'd0;
            reasons_reg.nack_reason  <= 32'd1;
            reasons_reg.busy_reason  <= 32'd2;
            reasons_reg.read_reason  <= 32'd3;
            reasons_reg.write_reason <= 32'd4;
        end
        else if (write_en)
        begin
            case (index)
                rfc_pkg::REG_ACK:   reasons_reg.ack_reason   <= pwdata;
                rfc_pkg::REG_NACK:  reasons_reg.nack_reason  <= pwdata;
                rfc_pkg::REG_BUSY:  reasons_reg.busy_reason  <= pwdata;
                rfc_pkg::REG_READ:  reasons_reg.read_reason  <= pwdata;
                rfc_pkg::REG_WRITE: reasons_reg.write_reason <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (index)
            rfc_pkg::REG_ACK:   prdata = reasons_reg.ack_reason;
            rfc_pkg::REG_NACK:  prdata = reasons_reg.nack_reason;
            rfc_pkg::REG_BUSY:  prdata = reasons_reg.busy_reason;
            rfc_pkg::REG_READ:  prdata = reasons_reg.read_reason;
            rfc_pkg::REG_WRITE: prdata = reasons_reg.write_reason;
            default:            prdata = 32'd0;
        endcase
    end

endmodule

/* rtl/core/rfc_frame.sv */
// ----------------------------------------------------------------------------
// rfc_frame
// Per-byte frame parser and CRC word accumulator with end-of-frame snapshot.
// ----------------------------------------------------------------------------
module rfc_frame
#(
    parameter int MAX_PAYLOAD = 255
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rx_valid,
    output logic              rx_stall,
    input  rfc_pkg::in_word_t rx_word,
    input  logic              snap_take,
    output logic              snap_valid,
    output rfc_pkg::snap_t    snap
);

    localparam logic [8:0] MAX_FRAME =
        9'(rfc_pkg::HDR_BYTES + MAX_PAYLOAD + rfc_pkg::CRC_BYTES);

    logic [8:0]  cnt_reg, cnt_next;
    logic [31:0] crc_reg, crc_next;
    logic [31:0] gather_reg, gather_next;
    logic [31:0] seq_reg, seq_next;
    logic [31:0] reason_reg, reason_next;
    logic [7:0]  len_reg, len_next;
    logic [31:0] rcrc_reg, rcrc_next;
    logic        snap_valid_reg, snap_valid_next;
    rfc_pkg::snap_t snap_reg;

    logic        accept;
    logic [31:0] byte_w;
    logic [31:0] gather_w;
    logic [7:0]  len_cur;
    logic [8:0]  body_end;
    logic [1:0]  hdr_lane;
    logic [1:0]  crc_lane;

    assign rx_stall   = snap_valid_reg && !snap_take;
    assign accept     = rx_valid && !rx_stall;
    assign snap_valid = snap_valid_reg;
    assign snap       = snap_reg;

    assign byte_w   = {24'd0, rx_word.rx_byte};
    assign hdr_lane = cnt_reg[1:0] - 2'd1;
    // length as it stands once this byte is taken
    assign len_cur  = (cnt_reg == 9'd9) ? rx_word.rx_byte : len_reg;
    assign body_end = 9'(rfc_pkg::HDR_BYTES) + {1'b0, len_cur};
    assign crc_lane = 2'(cnt_reg - body_end);

    always_comb
    begin
        cnt_next    = cnt_reg;
        crc_next    = crc_reg;
        gather_next = gather_reg;
        seq_next    = seq_reg;
        reason_next = reason_reg;
        len_next    = len_reg;
        rcrc_next   = rcrc_reg;
        gather_w    = gather_reg | (byte_w << {cnt_reg[1:0], 3'b000});
        if (cnt_reg < MAX_FRAME)
        begin
            if (cnt_reg >= 9'd1 && cnt_reg <= 9'd4)
            begin
                seq_next = seq_reg | (byte_w << {hdr_lane, 3'b000});
            end
            else if (cnt_reg >= 9'd5 && cnt_reg <= 9'd8)
            begin
                reason_next = reason_reg | (byte_w << {hdr_lane, 3'b000});
            end
            else if (cnt_reg == 9'd9)
            begin
                len_next = rx_word.rx_byte;
            end

            if (cnt_reg < body_end)
            begin
                // fold a full word, or the zero padded tail of the body
                if (cnt_reg[1:0] == 2'b11 || cnt_reg == body_end - 9'd1)
                begin
                    crc_next    = rfc_pkg::crc_word(crc_reg, gather_w);
                    gather_next = 32'd0;
                end
                else
                begin
                    gather_next = gather_w;
                end
            end
            else if (cnt_reg < body_end + 9'd4)
            begin
                rcrc_next = rcrc_reg | (byte_w << {crc_lane, 3'b000});
            end
            cnt_next = cnt_reg + 9'd1;
        end
    end

    always_comb
    begin
        snap_valid_next = snap_valid_reg;
        if (accept && rx_word.last_byte)
        begin
            snap_valid_next = 1'b1;
        end
        else if (snap_take)
        begin
            snap_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg        <= 9'd0;
            crc_reg        <= rfc_pkg::CRC_SEED;
            gather_reg     <= 32'd0;
            seq_reg        <= 32'd0;
            reason_reg     <= 32'd0;
            len_reg        <= 8'd0;
            rcrc_reg       <= 32'd0;
            snap_valid_reg <= 1'b0;
        end
        else
        begin
            snap_valid_reg <= snap_valid_next;
            if (accept)
            begin
                if (rx_word.last_byte)
                begin
                    // frame done: clear for the next one
                    cnt_reg    <= 9'd0;
                    crc_reg    <= rfc_pkg::CRC_SEED;
                    gather_reg <= 32'd0;
                    seq_reg    <= 32'd0;
                    reason_reg <= 32'd0;
                    len_reg    <= 8'd0;
                    rcrc_reg   <= 32'd0;
                end
                else
                begin
                    cnt_reg    <= cnt_next;
                    crc_reg    <= crc_next;
                    gather_reg <= gather_next;
                    seq_reg    <= seq_next;
                    reason_reg <= reason_next;
                    len_reg    <= len_next;
                    rcrc_reg   <= rcrc_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && rx_word.last_byte)
        begin
            snap_reg.byte_count   <= cnt_next;
            snap_reg.length       <= len_next;
            snap_reg.seq          <= seq_next;
            snap_reg.reason       <= reason_next;
            snap_reg.crc          <= crc_next;
            snap_reg.rx_crc       <= rcrc_next;
            snap_reg.expected_seq <= rx_word.expected_seq;
        end
    end

endmodule

/* rtl/core/rfc_judge.sv */
// ----------------------------------------------------------------------------
// rfc_judge
// Length, CRC and sequence checks, reason classification and result register.
// ----------------------------------------------------------------------------
module rfc_judge
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               snap_valid,
    input  rfc_pkg::snap_t     snap,
    output logic               snap_take,
    input  rfc_pkg::reasons_t  reasons,
    output logic               res_valid,
    input  logic               res_stall,
    output rfc_pkg::out_word_t res_word
);

    logic               res_valid_reg, res_valid_next;
    rfc_pkg::out_word_t res_word_reg;
    rfc_pkg::out_word_t res_word_next;

    logic       hdr_ok;
    logic       seq_ok;
    logic       crc_avail;
    logic [8:0] body_end;
    logic [8:0] need;
    rfc_pkg::frame_status_t status;
    rfc_pkg::verdict_t      verdict;

    assign snap_take = snap_valid && (!res_valid_reg || !res_stall);
    assign res_valid = res_valid_reg;
    assign res_word  = res_word_reg;

    assign body_end  = 9'(rfc_pkg::HDR_BYTES) + {1'b0, snap.length};
    assign need      = body_end + 9'(rfc_pkg::CRC_BYTES);
    assign hdr_ok    = snap.byte_count >= 9'(rfc_pkg::HDR_BYTES);
    assign seq_ok    = hdr_ok && (snap.seq == snap.expected_seq);
    assign crc_avail = hdr_ok && (snap.byte_count >= body_end);

    always_comb
    begin
        if (!hdr_ok)
        begin
            status = rfc_pkg::STAT_SHORT_HDR;
        end
        else if (snap.byte_count < need)
        begin
            status = rfc_pkg::STAT_SHORT_BODY;
        end
        else if (snap.byte_count > need)
        begin
            status = rfc_pkg::STAT_LONG;
        end
        else if (snap.crc != snap.rx_crc)
        begin
            status = rfc_pkg::STAT_CRC_BAD;
        end
        else
        begin
            status = rfc_pkg::STAT_OK;
        end
    end

    // bad frame or wrong sequence wins, then reason codes in priority order
    always_comb
    begin
        if (status != rfc_pkg::STAT_OK || !seq_ok)
        begin
            verdict = rfc_pkg::VERD_NACK;
        end
        else if (snap.reason == reasons.ack_reason)
        begin
            verdict = rfc_pkg::VERD_ACK;
        end
        else if (snap.reason == reasons.read_reason || snap.reason == reasons.write_reason)
        begin
            verdict = rfc_pkg::VERD_ACCEPTED;
        end
        else if (snap.reason == reasons.nack_reason)
        begin
            verdict = rfc_pkg::VERD_NACK;
        end
        else if (snap.reason == reasons.busy_reason)
        begin
            verdict = rfc_pkg::VERD_BUSY;
        end
        else
        begin
            verdict = rfc_pkg::VERD_ACCEPTED;
        end
    end

    always_comb
    begin
        res_word_next.frame_status   = status;
        res_word_next.verdict        = verdict;
        res_word_next.seq_matches    = seq_ok;
        res_word_next.reason_seen    = hdr_ok ? snap.reason : 32'd0;
        res_word_next.seq_seen       = hdr_ok ? snap.seq : 32'd0;
        res_word_next.payload_length = hdr_ok ? snap.length : 8'd0;
        res_word_next.bytes_received = snap.byte_count;
        res_word_next.computed_crc   = crc_avail ? snap.crc : 32'd0;
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (snap_take)
        begin
            res_valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (snap_take)
        begin
            res_word_reg <= res_word_next;
        end
    end

endmodule
